[design/integer_divide_remainder_defines.svh]
// assertion macros used by the integer divider top level
`ifndef INTEGER_DIVIDE_REMAINDER_DEFINES_SVH
`define INTEGER_DIVIDE_REMAINDER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define IDR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("integer divider check failed");

// implication over a fixed number of cycles, checked outside reset
`define IDR_ASSERT_AFTER(label, clk, rst_n, ante, dly, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("integer divider latency check failed");

`endif

[design/idr_pkg.sv]
// shared constants and types of the integer divider
package idr_pkg;

    // fixed port widths
    localparam int FIELD_W = 32;
    localparam int MODE_W  = 2;

    // default datapath width
    localparam int DATA_WIDTH_DEF = 32;

    // operation modes
    localparam logic [MODE_W-1:0] MODE_UQUO = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UREM = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SQUO = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SREM = 2'd3;

    // per-request control carried along the cell chain
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              a_neg;
        logic              b_neg;
    } idr_ctrl_t;

endpackage

[design/idr_cell.sv]
// one restoring division step with its pipeline register
module idr_cell #(
    parameter int W = idr_pkg::DATA_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  idr_pkg::idr_ctrl_t in_ctrl,
    input  logic [W-1:0]       in_part,
    input  logic [W-1:0]       in_nq,
    input  logic [W-1:0]       in_den,
    output logic               out_valid,
    output idr_pkg::idr_ctrl_t out_ctrl,
    output logic [W-1:0]       out_part,
    output logic [W-1:0]       out_nq,
    output logic [W-1:0]       out_den
);

    logic               valid_reg;
    idr_pkg::idr_ctrl_t ctrl_reg;
    logic [W-1:0]       part_reg;
    logic [W-1:0]       part_next;
    logic [W-1:0]       nq_reg;
    logic [W-1:0]       nq_next;
    logic [W-1:0]       den_reg;
    logic [W:0]         shifted;
    logic [W:0]         diff;
    logic               ge;

    // shift in the next dividend bit and try the subtraction
    always_comb
    begin
        shifted   = {in_part, in_nq[W-1]};
        diff      = shifted - {1'b0, in_den};
        ge        = !diff[W];
        part_next = ge ? diff[W-1:0] : shifted[W-1:0];
        nq_next   = {in_nq[W-2:0], ge};
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ctrl_reg <= in_ctrl;
        part_reg <= part_next;
        nq_reg   <= nq_next;
        den_reg  <= in_den;
    end

    assign out_valid = valid_reg;
    assign out_ctrl  = ctrl_reg;
    assign out_part  = part_reg;
    assign out_nq    = nq_reg;
    assign out_den   = den_reg;

endmodule

[design/integer_divide_remainder.sv]
// integer divider top level: operand prep, cell chain and sign fix-up
//
// Usage: a request (mode, dividend, divisor) is taken at each rising clock
// edge where start is high and busy is low. busy is never raised, so one
// request may be issued every cycle. Each request yields one result, shown
// on result for exactly one cycle with strobe high.
// Modes: unsigned quotient, unsigned remainder, signed quotient, signed
// remainder. Signed modes divide magnitudes; the quotient is negated when
// the operand signs differ and the remainder keeps the dividend's sign.
// A zero divisor gives an all-ones quotient magnitude and the dividend as
// remainder.
// Pipeline: one prep stage,
// one registered cell per quotient bit, one output stage.
// Throughput: one request per cycle, set by the fully pipelined cell chain.
// Reset: rst_n clears all valid flags; requests in flight are dropped.
// The receiver cannot stall; results are delivered in request order.
module integer_divide_remainder #(
    parameter int DATA_WIDTH = idr_pkg::DATA_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [idr_pkg::MODE_W-1:0]   mode,
    input  logic [idr_pkg::FIELD_W-1:0]  dividend,
    input  logic [idr_pkg::FIELD_W-1:0]  divisor,
    output logic                         strobe,
    output logic [idr_pkg::FIELD_W-1:0]  result
);

`include "integer_divide_remainder_defines.svh"

    localparam int W   = DATA_WIDTH;
    localparam int LAT = DATA_WIDTH + 2;

    logic [W-1:0]       a_w;
    logic [W-1:0]       b_w;
    logic               signed_mode;
    logic               a_neg;
    logic               b_neg;
    logic               take;

    logic               prep_valid_reg;
    idr_pkg::idr_ctrl_t prep_ctrl_reg;
    logic [W-1:0]       prep_num_reg;
    logic [W-1:0]       prep_den_reg;

    logic               chain_valid [0:W];
    idr_pkg::idr_ctrl_t chain_ctrl  [0:W];
    logic [W-1:0]       chain_part  [0:W];
    logic [W-1:0]       chain_nq    [0:W];
    logic [W-1:0]       chain_den   [0:W];

    logic [W-1:0]       quo;
    logic [W-1:0]       rem;
    idr_pkg::idr_ctrl_t fin_ctrl;
    logic [W-1:0]       res_w;
    logic               strobe_reg;
    logic [W-1:0]       result_reg;

    // never holds requests off
    assign busy = 1'b0;
    assign take = start && !busy;

    // operand width fit and sign detection
    always_comb
    begin
        a_w         = W'(dividend);
        b_w         = W'(divisor);
        signed_mode = (mode == idr_pkg::MODE_SQUO) || (mode == idr_pkg::MODE_SREM);
        a_neg       = signed_mode && a_w[W-1];
        b_neg       = signed_mode && b_w[W-1];
    end

    // prep stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
        end
        else
        begin
            prep_valid_reg <= take;
        end
    end

    // prep stage payload: magnitudes
    always_ff @(posedge clk)
    begin
        prep_ctrl_reg.mode  <= mode;
        prep_ctrl_reg.a_neg <= a_neg;
        prep_ctrl_reg.b_neg <= b_neg;
        prep_num_reg        <= a_neg ? (~a_w + 1'b1) : a_w;
        prep_den_reg        <= b_neg ? (~b_w + 1'b1) : b_w;
    end

    // head of the cell chain
    assign chain_valid[0] = prep_valid_reg;
    assign chain_ctrl[0]  = prep_ctrl_reg;
    assign chain_part[0]  = '0;
    assign chain_nq[0]    = prep_num_reg;
    assign chain_den[0]   = prep_den_reg;

    // one cell per quotient bit
    for (genvar i = 0; i < W; i++)
    begin : g_cell
        idr_cell #(
            .W (W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_ctrl   (chain_ctrl[i]),
            .in_part   (chain_part[i]),
            .in_nq     (chain_nq[i]),
            .in_den    (chain_den[i]),
            .out_valid (chain_valid[i+1]),
            .out_ctrl  (chain_ctrl[i+1]),
            .out_part  (chain_part[i+1]),
            .out_nq    (chain_nq[i+1]),
            .out_den   (chain_den[i+1])
        );
    end

    // sign fix-up and mode select
    always_comb
    begin
        quo      = chain_nq[W];
        rem      = chain_part[W];
        fin_ctrl = chain_ctrl[W];
        unique case (fin_ctrl.mode)
            idr_pkg::MODE_UQUO: res_w = quo;
            idr_pkg::MODE_UREM: res_w = rem;
            idr_pkg::MODE_SQUO:
                res_w = (fin_ctrl.a_neg != fin_ctrl.b_neg) ? (~quo + 1'b1) : quo;
            idr_pkg::MODE_SREM: res_w = fin_ctrl.a_neg ? (~rem + 1'b1) : rem;
            default:            res_w = quo;
        endcase
    end

    // output strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= chain_valid[W];
        end
    end

    // output data
    always_ff @(posedge clk)
    begin
        result_reg <= res_w;
    end

    assign strobe = strobe_reg;
    assign result = idr_pkg::FIELD_W'(result_reg);

    // every accepted request gives a result after the fixed latency
    `IDR_ASSERT_AFTER(a_latency, clk, rst_n, take, LAT, strobe)

    // no result without a request the fixed latency earlier
    `IDR_ASSERT_NOW(a_no_spurious, clk, rst_n, strobe, $past(take, LAT))

    // unsigned remainder stays below a nonzero divisor
    `IDR_ASSERT_NOW(a_rem_bound, clk, rst_n,
        strobe && $past(take && (mode == idr_pkg::MODE_UREM) && (W'(divisor) != '0), LAT),
        W'(result) < W'($past(divisor, LAT)))

endmodule

[tb/integer_divide_remainder_tb.sv]
// self-checking testbench for the pipelined integer divider
module integer_divide_remainder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = idr_pkg::DATA_WIDTH_DEF;
    localparam int RANDOM_REQUESTS = 800;
    localparam int DRAIN_CYCLES = W + 8;

    // one directed request, with an optional hand-written expected result
    typedef struct packed {
        logic [idr_pkg::MODE_W-1:0]  op;
        logic [idr_pkg::FIELD_W-1:0] num;
        logic [idr_pkg::FIELD_W-1:0] den;
        logic                        typed;
        logic [idr_pkg::FIELD_W-1:0] value;
    } div_row_t;

    // one outstanding division and the result it must produce
    typedef struct {
        logic [idr_pkg::MODE_W-1:0]  op;
        logic [idr_pkg::FIELD_W-1:0] num;
        logic [idr_pkg::FIELD_W-1:0] den;
        logic [idr_pkg::FIELD_W-1:0] value;
    } div_pending_t;

    localparam int DIR_N = 25;
    localparam div_row_t DIR_ROWS [DIR_N] = '{
        '{idr_pkg::MODE_UQUO, 32'd100,        32'd7,        1'b0, 32'd0},
        '{idr_pkg::MODE_UQUO, 32'hffffffff,   32'd1,        1'b1, 32'hffffffff},
        '{idr_pkg::MODE_UQUO, 32'd0,          32'hffffffff, 1'b1, 32'd0},
        '{idr_pkg::MODE_UQUO, 32'hffffffff,   32'hffffffff, 1'b1, 32'd1},
        '{idr_pkg::MODE_UQUO, 32'h12345678,   32'd0,        1'b1, 32'hffffffff},
        '{idr_pkg::MODE_UREM, 32'h12345678,   32'd0,        1'b1, 32'h12345678},
        '{idr_pkg::MODE_UREM, 32'hffffffff,   32'd10,       1'b0, 32'd0},
        '{idr_pkg::MODE_UREM, 32'd0,          32'd0,        1'b1, 32'd0},
        '{idr_pkg::MODE_UQUO, 32'd0,          32'd0,        1'b1, 32'hffffffff},
        '{idr_pkg::MODE_SQUO, 32'd7,          32'hfffffffe, 1'b0, 32'd0},
        '{idr_pkg::MODE_SQUO, 32'hfffffff9,   32'd2,        1'b0, 32'd0},
        '{idr_pkg::MODE_SQUO, 32'hfffffff9,   32'hfffffffe, 1'b0, 32'd0},
        '{idr_pkg::MODE_SREM, 32'hfffffff9,   32'd2,        1'b0, 32'd0},
        '{idr_pkg::MODE_SREM, 32'd7,          32'hfffffffe, 1'b0, 32'd0},
        '{idr_pkg::MODE_SQUO, 32'h80000000,   32'hffffffff, 1'b1, 32'h80000000},
        '{idr_pkg::MODE_SREM, 32'h80000000,   32'hffffffff, 1'b1, 32'd0},
        '{idr_pkg::MODE_SQUO, 32'd5,          32'd0,        1'b1, 32'hffffffff},
        '{idr_pkg::MODE_SQUO, 32'hfffffffb,   32'd0,        1'b1, 32'd1},
        '{idr_pkg::MODE_SQUO, 32'd0,          32'd0,        1'b1, 32'hffffffff},
        '{idr_pkg::MODE_SREM, 32'hfffffffb,   32'd0,        1'b1, 32'hfffffffb},
        '{idr_pkg::MODE_SQUO, 32'h7fffffff,   32'd1,        1'b1, 32'h7fffffff},
        '{idr_pkg::MODE_SQUO, 32'h80000000,   32'd1,        1'b1, 32'h80000000},
        '{idr_pkg::MODE_SREM, 32'h80000000,   32'h7fffffff, 1'b0, 32'd0},
        '{idr_pkg::MODE_UREM, 32'h80000000,   32'hffffffff, 1'b0, 32'd0},
        '{idr_pkg::MODE_SQUO, 32'h7fffffff,   32'h80000000, 1'b0, 32'd0}
    };

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic [idr_pkg::MODE_W-1:0]  mode = idr_pkg::MODE_UQUO;
    logic [idr_pkg::FIELD_W-1:0] dividend = '0;
    logic [idr_pkg::FIELD_W-1:0] divisor = '0;
    logic                        strobe;
    logic [idr_pkg::FIELD_W-1:0] result;

    div_pending_t pending_results [$];
    int           mismatch_count = 0;
    logic         steady_flow = 1'b0;

    integer_divide_remainder uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .mode     (mode),
        .dividend (dividend),
        .divisor  (divisor),
        .strobe   (strobe),
        .result   (result)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // expected quotient or remainder by restoring shift-subtract on magnitudes
    function automatic logic [idr_pkg::FIELD_W-1:0] predict_division(
        input logic [idr_pkg::MODE_W-1:0]  op,
        input logic [idr_pkg::FIELD_W-1:0] num,
        input logic [idr_pkg::FIELD_W-1:0] den
    );
        logic           signed_op;
        logic           num_neg;
        logic           den_neg;
        logic           carry;
        logic [W-1:0]   num_mag;
        logic [W-1:0]   den_mag;
        logic [W-1:0]   quo;
        logic [W-1:0]   part;
        int             pos;
        signed_op = (op == idr_pkg::MODE_SQUO) || (op == idr_pkg::MODE_SREM);
        num_neg = signed_op && num[W-1];
        den_neg = signed_op && den[W-1];
        num_mag = num_neg ? W'(0) - num[W-1:0] : num[W-1:0];
        den_mag = den_neg ? W'(0) - den[W-1:0] : den[W-1:0];
        quo = '0;
        part = '0;
        // zero divisor: all-ones quotient, dividend as remainder
        if (den_mag == '0)
        begin
            quo = '1;
            part = num_mag;
        end
        else
        begin
            for (pos = W - 1; pos >= 0; pos--)
            begin
                carry = part[W-1];
                part = {part[W-2:0], num_mag[pos]};
                if (carry || part >= den_mag)
                begin
                    part = part - den_mag;
                    quo[pos] = 1'b1;
                end
            end
        end
        case (op)
            idr_pkg::MODE_UQUO: return idr_pkg::FIELD_W'(quo);
            idr_pkg::MODE_UREM: return idr_pkg::FIELD_W'(part);
            idr_pkg::MODE_SQUO:
                return idr_pkg::FIELD_W'((num_neg != den_neg) ? W'(0) - quo : quo);
            default:   return idr_pkg::FIELD_W'(num_neg ? W'(0) - part : part);
        endcase
    endfunction

    // operand mix: full range, small, small negative, corner values, shifted
    function automatic logic [idr_pkg::FIELD_W-1:0] random_operand();
        logic [idr_pkg::FIELD_W-1:0] corners [6];
        corners = '{32'd0, 32'd1, 32'hffffffff, 32'h80000000, 32'h7fffffff, 32'hfffffffe};
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return $urandom_range(0, 255);
            2:       return idr_pkg::FIELD_W'(0) - $urandom_range(1, 255);
            3:       return corners[$urandom_range(0, 5)];
            default: return $urandom >> $urandom_range(0, idr_pkg::FIELD_W - 1);
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // issue one request, after a random gap unless steady_flow is set, and record its expected result
    task automatic issue_division(
        input logic [idr_pkg::MODE_W-1:0]  op,
        input logic [idr_pkg::FIELD_W-1:0] num,
        input logic [idr_pkg::FIELD_W-1:0] den,
        input logic                        typed,
        input logic [idr_pkg::FIELD_W-1:0] typed_value
    );
        int           gap;
        div_pending_t entry;
        gap = steady_flow ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        mode <= op;
        dividend <= num;
        divisor <= den;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        entry.op = op;
        entry.num = num;
        entry.den = den;
        entry.value = typed ? typed_value : predict_division(op, num, den);
        pending_results.push_back(entry);
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // compare each strobed result with the oldest outstanding request
    always @(posedge clk)
    begin
        div_pending_t head;
        if (rst_n && strobe === 1'b1)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result %h with no request outstanding", result));
            else
            begin
                head = pending_results.pop_front();
                if (result !== head.value)
                    report_mismatch($sformatf("mode %0d %h / %h gave %h, expected %h",
                        head.op, head.num, head.den, result, head.value));
            end
        end
    end

    // stimulus
    initial
    begin
        int                         i;
        logic [idr_pkg::MODE_W-1:0] op;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners
        for (i = 0; i < DIR_N; i++)
            issue_division(DIR_ROWS[i].op, DIR_ROWS[i].num, DIR_ROWS[i].den,
                DIR_ROWS[i].typed, DIR_ROWS[i].value);
        wait_for_results();

        // random requests with bursts of back-to-back issue
        for (i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if ($urandom_range(0, 39) == 0)
                steady_flow = !steady_flow;
            if (i == RANDOM_REQUESTS / 2)
                wait_for_results();
            op = idr_pkg::MODE_W'($urandom_range(int'(idr_pkg::MODE_UQUO),
                int'(idr_pkg::MODE_SREM)));
            issue_division(op, random_operand(), random_operand(), 1'b0, '0);
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("integer_divide_remainder regression: pass");
        else
            $display("integer_divide_remainder regression: fail");
        $finish;
    end

    // watchdog
    initial
    begin
        #2ms;
        $display("integer_divide_remainder regression: fail");
        $finish;
    end

endmodule
